FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: hdl/lfstr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfstr_pkg
// Types and constants of the lowest free slot timed release unit.
// ----------------------------------------------------------------------------
package lfstr_pkg;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  localparam int unsigned TotalW = 48;
  localparam logic [TotalW-1:0] TOTAL_MAX = {TotalW{1'b1}};

  typedef struct packed {
    logic        kind;
    logic [31:0] arrival_time;
    logic [31:0] amount;
    logic [31:0] hold_time;
    logic [3:0]  read_slot;
  } in_item_t;

  typedef struct packed {
    logic              granted;
    logic [3:0]        slot_index;
    logic [TotalW-1:0] total;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [31:0]       arrival_time;
    logic [31:0]       amount;
    logic [31:0]       hold_time;
    logic [3:0]        read_slot;
    logic              granted;
    logic [3:0]        slot_index;
    logic [TotalW-1:0] total;
  } token_t;

endpackage

FILE: hdl/lowest_free_slot_timed_release_unit.sv
`timescale 1ns / 1ps
// Result path: the token passes through the register of each cell in the row,
// then the output register. One item is in the row at a time; a new input is
// taken only after the token has left the row. The token walks the row one cell
// per cycle unless a stalled result holds the row, which delays the next item.
// Reset: all slots free, return times and totals zero, slot_count 16.
// ----------------------------------------------------------------------------
// lowest_free_slot_timed_release_unit
// Fixed-priority slot allocator with timed release, built as a row of cells.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lowest_free_slot_timed_release_unit #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [4:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lfstr_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lfstr_pkg::out_item_t out_data_o
);

  logic [4:0]           slot_count_q;
  logic                 inflight_q;
  logic                 out_valid_q;
  lfstr_pkg::out_item_t out_q;
  lfstr_pkg::token_t    chain [NUM_SLOTS+1];
  logic [NUM_SLOTS-1:0] tok_valid;
  logic                 en, last_valid, in_xfer;

  assign in_ready_o = !inflight_q;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign last_valid = chain[NUM_SLOTS].valid;
  assign en         = !(last_valid && out_valid_q && !out_ready_i);

  always_comb begin
    chain[0].valid        = in_xfer;
    chain[0].kind         = in_data_i.kind;
    chain[0].arrival_time = in_data_i.arrival_time;
    chain[0].amount       = in_data_i.amount;
    chain[0].hold_time    = in_data_i.hold_time;
    chain[0].read_slot    = in_data_i.read_slot;
    chain[0].granted      = 1'b0;
    chain[0].slot_index   = (in_data_i.kind == lfstr_pkg::KIND_READ) ? in_data_i.read_slot
                                                                     : 4'd0;
    chain[0].total        = '0;
  end

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    lfstr_cell #(
      .Idx(k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .slot_count_i(slot_count_q),
      .tok_i       (chain[k]),
      .tok_o       (chain[k+1])
    );
    assign tok_valid[k] = chain[k+1].valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= 5'd16;
      inflight_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        slot_count_q <= cfg_wdata_i;
      end
      if (in_xfer) begin
        inflight_q <= 1'b1;
      end else if (en && last_valid) begin
        inflight_q <= 1'b0;
      end
      if (en && last_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && last_valid) begin
      out_q.granted    <= chain[NUM_SLOTS].granted;
      out_q.slot_index <= chain[NUM_SLOTS].slot_index;
      out_q.total      <= chain[NUM_SLOTS].total;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_RST(a_one_token, $countones(tok_valid) <= 1, "more than one token in the slot row")
  `ASSERT_RST(a_inflight_match, inflight_q == (|tok_valid), "in-flight flag disagrees with row")
  `ASSERT_RST(a_out_from_row, $rose(out_valid_q) |-> $past(last_valid), "result without token")

endmodule

FILE: hdl/lfstr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfstr_cell
// One slot: busy flag, return time and total; processes the passing token.
// ----------------------------------------------------------------------------
module lfstr_cell #(
  parameter int Idx = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [4:0]        slot_count_i,
  input  lfstr_pkg::token_t tok_i,
  output lfstr_pkg::token_t tok_o
);

  localparam logic [3:0] IdxLow = 4'(Idx);

  logic                          busy_q, busy_d;
  logic [32:0]                   rt_q, rt_d;
  logic [lfstr_pkg::TotalW-1:0]  total_q, total_d;
  lfstr_pkg::token_t             tok_q, tok_d;
  logic                          due, is_req, active, grant, rd_hit;
  logic [lfstr_pkg::TotalW:0]    sum;
  logic [lfstr_pkg::TotalW-1:0]  sat;

  always_comb begin
    due    = busy_q && (rt_q <= {1'b0, tok_i.arrival_time});
    is_req = tok_i.valid && (tok_i.kind == lfstr_pkg::KIND_REQUEST);
    active = Idx < int'(slot_count_i);
    grant  = is_req && active && (!busy_q || due) && !tok_i.granted;
    rd_hit = tok_i.valid && (tok_i.kind == lfstr_pkg::KIND_READ)
             && (int'(tok_i.read_slot) == Idx);
    sum    = {1'b0, total_q} + (lfstr_pkg::TotalW+1)'(tok_i.amount);
    sat    = sum[lfstr_pkg::TotalW] ? lfstr_pkg::TOTAL_MAX
                                    : sum[lfstr_pkg::TotalW-1:0];
    busy_d  = busy_q;
    rt_d    = rt_q;
    total_d = total_q;
    tok_d   = tok_i;
    if (grant) begin
      busy_d           = 1'b1;
      rt_d             = {1'b0, tok_i.arrival_time} + {1'b0, tok_i.hold_time};
      total_d          = sat;
      tok_d.granted    = 1'b1;
      tok_d.slot_index = IdxLow;
      tok_d.total      = sat;
    end else if (is_req && due) begin
      busy_d = 1'b0;
    end
    if (rd_hit) begin
      tok_d.total = total_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      rt_q    <= '0;
      total_q <= '0;
      tok_q   <= '0;
    end else if (en_i) begin
      busy_q  <= busy_d;
      rt_q    <= rt_d;
      total_q <= total_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lowest free slot timed release unit. A scoreboard
// class tracks slot busy flags, return times and saturating totals, predicts
// one result per input transfer and compares results in order. Stimulus runs
// directed cases, a run of maximum amounts on slot 0, paced random phases over
// several slot counts, and a closing set at the ends of the time range.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_SLOTS = 16;

  class slot_scoreboard;
    logic [4:0]           slot_count;
    bit                   slot_busy[NUM_SLOTS];
    logic [32:0]          return_at[NUM_SLOTS];
    logic [47:0]          slot_sum[NUM_SLOTS];
    lfstr_pkg::out_item_t expected_q[$];
    int                   errors;

    function new();
      slot_count = 5'd16;
      errors = 0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        slot_busy[k] = 1'b0;
        return_at[k] = '0;
        slot_sum[k] = '0;
      end
    endfunction

    function void write_count(logic [4:0] value);
      slot_count = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_transfer(lfstr_pkg::in_item_t it);
      lfstr_pkg::out_item_t res;
      int                   active;
      bit                   found;
      logic [48:0]          acc;
      res = '0;
      found = 1'b0;
      if (it.kind == lfstr_pkg::KIND_READ) begin
        res.slot_index = it.read_slot;
        res.total = slot_sum[it.read_slot];
      end else begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
          if (slot_busy[k] && return_at[k] <= {1'b0, it.arrival_time}) slot_busy[k] = 1'b0;
        end
        active = (slot_count < NUM_SLOTS) ? int'(slot_count) : NUM_SLOTS;
        for (int k = 0; k < active; k++) begin
          if (!found && !slot_busy[k]) begin
            found = 1'b1;
            acc = {1'b0, slot_sum[k]} + {17'd0, it.amount};
            slot_sum[k] = acc[48] ? lfstr_pkg::TOTAL_MAX : acc[47:0];
            slot_busy[k] = 1'b1;
            return_at[k] = {1'b0, it.arrival_time} + {1'b0, it.hold_time};
            res.granted = 1'b1;
            res.slot_index = k[3:0];
            res.total = slot_sum[k];
          end
        end
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(lfstr_pkg::out_item_t got);
      lfstr_pkg::out_item_t exp_res;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: granted=%0d slot=%0d total=%h",
                   got.granted, got.slot_index, got.total);
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.granted !== exp_res.granted || got.slot_index !== exp_res.slot_index ||
          got.total !== exp_res.total) begin
        errors++;
        if (errors <= 10)
          $display("result error: exp granted=%0d slot=%0d total=%h,",
                   exp_res.granted, exp_res.slot_index, exp_res.total,
                   " got granted=%0d slot=%0d total=%h",
                   got.granted, got.slot_index, got.total);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [4:0]           cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  lfstr_pkg::in_item_t  in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  lfstr_pkg::out_item_t out_data_o;

  slot_scoreboard sb = new();

  logic [15:0] ready_pat = 16'hFFFF;
  int          ready_div = 1;
  int          tick = 0;
  bit          paced = 1'b0;
  int          burst_left = 0;

  lowest_free_slot_timed_release_unit #(.NUM_SLOTS(NUM_SLOTS)) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
    tick++;
    out_ready_i <= ready_pat[(tick / ready_div) % 16];
  end

  task automatic push_item(input lfstr_pkg::in_item_t it);
    int gap;
    if (paced) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_transfer(it);
  endtask

  task automatic send_req(input logic [31:0] at, input logic [31:0] amt,
                          input logic [31:0] hold);
    lfstr_pkg::in_item_t it;
    it.kind = lfstr_pkg::KIND_REQUEST;
    it.arrival_time = at;
    it.amount = amt;
    it.hold_time = hold;
    it.read_slot = 4'($urandom_range(0, 15));
    push_item(it);
  endtask

  task automatic send_read(input logic [3:0] slot);
    lfstr_pkg::in_item_t it;
    it.kind = lfstr_pkg::KIND_READ;
    it.arrival_time = $urandom;
    it.amount = $urandom;
    it.hold_time = $urandom;
    it.read_slot = slot;
    push_item(it);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (NUM_SLOTS + 4) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [4:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_count(value);
  endtask

  initial begin
    #60_000_000;
    $display("lowest_free_slot_timed_release_unit: mismatch");
    $finish;
  end

  initial begin
    logic [31:0] cur_time;
    logic [31:0] amt;
    logic [4:0]  cnt;
    int          hold_cap;
    int          step_cap;
    int          sel;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: same-time release, amount extremes, drops, inactive slots
    paced = 1'b1;
    send_read(4'd0);
    send_req(32'd100, 32'd0, 32'd0);
    send_req(32'd100, 32'hFFFF_FFFF, 32'd5);
    send_req(32'd100, 32'd1, 32'd10);
    send_req(32'd104, 32'h8000_0000, 32'd20);
    send_req(32'd105, 32'h0000_0001, 32'd30);
    send_read(4'd0);
    send_read(4'd15);
    settle();
    write_count(5'd0);
    send_req(32'd200, 32'd7, 32'd0);
    settle();
    write_count(5'd2);
    send_req(32'd300, 32'd3, 32'd100);
    send_req(32'd300, 32'd4, 32'd100);
    send_req(32'd310, 32'd5, 32'd0);
    settle();
    write_count(5'd1);
    send_req(32'd400, 32'd6, 32'd500);
    settle();
    write_count(5'd2);
    send_req(32'd410, 32'd9, 32'd50);
    send_req(32'd300, 32'd11, 32'd50);
    send_read(4'd1);

    // drive slot 0 with back-to-back maximum amounts
    settle();
    write_count(5'd1);
    paced = 1'b0;
    for (int i = 0; i < 20; i++) send_req(32'd2000, 32'hFFFF_FFFF, 32'd0);
    send_read(4'd0);

    cur_time = 32'd3000;
    paced = 1'b1;
    for (int ph = 0; ph < 10; ph++) begin
      settle();
      case (ph)
        0: cnt = 5'd31;
        1: cnt = 5'd17;
        2: cnt = 5'd16;
        3: cnt = 5'd1;
        default: begin
          sel = $urandom_range(0, 7);
          cnt = (sel == 0) ? 5'd0 : (sel == 1) ? 5'($urandom_range(17, 31))
                                               : 5'($urandom_range(1, 16));
        end
      endcase
      write_count(cnt);
      ready_pat = (ph % 3 == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      ready_div = $urandom_range(1, 4);
      sel = $urandom_range(0, 2);
      hold_cap = (sel == 0) ? 4 : (sel == 1) ? 40 : 400;
      sel = $urandom_range(0, 2);
      step_cap = (sel == 0) ? 0 : (sel == 1) ? 3 : 20;
      for (int i = 0; i < 190; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
          send_read(4'($urandom_range(0, 15)));
        end else if (sel < 25) begin
          send_req(cur_time - 32'($urandom_range(0, 200)), $urandom,
                   32'($urandom_range(0, hold_cap)));
        end else begin
          cur_time += 32'($urandom_range(0, step_cap));
          amt = (sel < 28) ? 32'hFFFF_FFFF : (sel < 31) ? 32'd0 : 32'($urandom);
          send_req(cur_time, amt, 32'($urandom_range(0, hold_cap)));
        end
      end
    end

    // close at the ends of the time range
    settle();
    write_count(5'd16);
    ready_pat = 16'hFFFF;
    send_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_req(32'hFFFF_FFFF, 32'd12, 32'hFFFF_FFFF);
    send_req(32'hFFFF_FFFF, 32'd13, 32'd0);
    send_req(32'hFFFF_FFFF, 32'd14, 32'd0);
    send_req(32'd0, 32'd15, 32'hFFFF_FFFF);
    for (int s = 0; s < NUM_SLOTS; s++) send_read(4'(s));

    settle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("lowest_free_slot_timed_release_unit: match");
    else
      $display("lowest_free_slot_timed_release_unit: mismatch");
    $finish;
  end

endmodule
